// ===== sv/cleb_pkg.sv =====
// ----------------------------------------------------------------------------
// Cursor line-edit buffer package
// Field widths, command codes, status codes and the default capacity shared
// by the buffer unit and its testbench.
// ----------------------------------------------------------------------------
package cleb_pkg;

  localparam int KIND_W       = 3;
  localparam int CHAR_W       = 8;
  localparam int POS_W        = 10;
  localparam int LEN_W        = 11;
  localparam int STAT_W       = 2;
  localparam int CAPACITY_DEF = 1024;

  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LEFT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RIGHT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

  localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BOUNDARY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd3;

endpackage

// ===== sv/cleb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module cleb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/cursor_line_edit_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// Cursor line-edit buffer
// Text held as two stacks in synchronous RAMs, split at the cursor.
// ----------------------------------------------------------------------------
// Each command runs in an address step and an execute step: in the cycle in which start is taken,
// the stack tops (or the entry at the read position) are addressed in the two
// RAMs; in the next cycle, with busy high, the read data comes back, the
// stack that takes a character is written and the counts updated. The single
// result appears on the out_ ports with out_valid for exactly one cycle right
// after that, and a new command may be started in that same cycle; no new
// command is taken while busy is high. The result cannot be held off, so it
// must be captured when out_valid is high. The stores need no clearing after reset.
module cursor_line_edit_buffer_unit
  import cleb_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [CHAR_W-1:0] in_char_in,
  input  logic [POS_W-1:0]  in_position,
  output logic              out_valid,
  output logic [CHAR_W-1:0] out_char_out,
  output logic [LEN_W-1:0]  out_text_length,
  output logic [LEN_W-1:0]  out_cursor_at,
  output logic [STAT_W-1:0] out_status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic              state_r, state_nxt;
  logic [CW-1:0]     left_cnt_r, left_cnt_nxt;
  logic [CW-1:0]     right_cnt_r, right_cnt_nxt;
  logic [KIND_W-1:0] kind_r;
  logic [CHAR_W-1:0] char_r;
  logic              sel_right_r;
  logic              range_r;

  logic              out_valid_r;
  logic [CHAR_W-1:0] char_out_r, char_out_nxt;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  cur_r;
  logic [STAT_W-1:0] stat_r, stat_nxt;

  logic              accept;
  logic [CW-1:0]     total;
  logic [PW-1:0]     pos_ext;
  logic [PW-1:0]     lc_ext;
  logic [PW-1:0]     tot_ext;

  logic              l_we, r_we;
  logic [AW-1:0]     l_waddr, r_waddr, l_raddr, r_raddr;
  logic [CHAR_W-1:0] l_wdata, r_wdata, l_rdata, r_rdata;

  assign busy   = (state_r == S_EXEC);
  assign accept = start && !busy;
  assign total  = left_cnt_r + right_cnt_r;

  assign pos_ext = PW'(in_position);
  assign lc_ext  = PW'(left_cnt_r);
  assign tot_ext = PW'(total);

  assign l_raddr = (in_kind == KIND_READ) ? AW'(pos_ext) : AW'(left_cnt_r - CW'(1));
  assign r_raddr = (in_kind == KIND_READ) ? AW'(tot_ext - pos_ext - PW'(1))
                                          : AW'(right_cnt_r - CW'(1));

  cleb_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(CAPACITY)
  ) u_left_ram (
    .clk  (clk),
    .we   (l_we),
    .waddr(l_waddr),
    .wdata(l_wdata),
    .raddr(l_raddr),
    .rdata(l_rdata)
  );

  cleb_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(CAPACITY)
  ) u_right_ram (
    .clk  (clk),
    .we   (r_we),
    .waddr(r_waddr),
    .wdata(r_wdata),
    .raddr(r_raddr),
    .rdata(r_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    left_cnt_nxt  = left_cnt_r;
    right_cnt_nxt = right_cnt_r;
    char_out_nxt  = '0;
    stat_nxt      = STAT_DONE;
    l_we          = 1'b0;
    r_we          = 1'b0;
    l_waddr       = AW'(left_cnt_r);
    r_waddr       = AW'(right_cnt_r);
    l_wdata       = char_r;
    r_wdata       = l_rdata;
    if (state_r == S_IDLE) begin
      if (start) begin
        state_nxt = S_EXEC;
      end
    end else begin
      state_nxt = S_IDLE;
      case (kind_r)
        KIND_INSERT: begin
          if (total >= CAP_C) begin
            stat_nxt = STAT_FULL;
          end else begin
            l_we         = 1'b1;
            left_cnt_nxt = left_cnt_r + CW'(1);
          end
        end
        KIND_LEFT: begin
          if (left_cnt_r == '0 || right_cnt_r >= CAP_C) begin
            stat_nxt = STAT_BOUNDARY;
          end else begin
            r_we          = 1'b1;
            left_cnt_nxt  = left_cnt_r - CW'(1);
            right_cnt_nxt = right_cnt_r + CW'(1);
          end
        end
        KIND_RIGHT: begin
          if (right_cnt_r == '0 || left_cnt_r >= CAP_C) begin
            stat_nxt = STAT_BOUNDARY;
          end else begin
            l_we          = 1'b1;
            l_wdata       = r_rdata;
            left_cnt_nxt  = left_cnt_r + CW'(1);
            right_cnt_nxt = right_cnt_r - CW'(1);
          end
        end
        KIND_DELETE: begin
          if (left_cnt_r == '0) begin
            stat_nxt = STAT_BOUNDARY;
          end else begin
            left_cnt_nxt = left_cnt_r - CW'(1);
          end
        end
        KIND_READ: begin
          if (range_r) begin
            stat_nxt = STAT_RANGE;
          end else begin
            char_out_nxt = sel_right_r ? r_rdata : l_rdata;
          end
        end
        default: begin
          stat_nxt = STAT_BOUNDARY;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      left_cnt_r  <= '0;
      right_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_cnt_r  <= left_cnt_nxt;
      right_cnt_r <= right_cnt_nxt;
      out_valid_r <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r      <= in_kind;
      char_r      <= in_char_in;
      sel_right_r <= !(pos_ext < lc_ext);
      range_r     <= (pos_ext >= tot_ext);
    end
    if (busy) begin
      char_out_r <= char_out_nxt;
      stat_r     <= stat_nxt;
      len_r      <= LEN_W'(left_cnt_nxt + right_cnt_nxt);
      cur_r      <= LEN_W'(left_cnt_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char_out    = char_out_r;
  assign out_text_length = len_r;
  assign out_cursor_at   = cur_r;
  assign out_status      = stat_r;

  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("Accepted command did not enter the execute cycle.");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy && out_valid)
    else $error("Execute cycle did not end with a result strobe.");

  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("Result strobe without a preceding execute cycle.");

  a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (left_cnt_r + right_cnt_r) <= CAP_C && total >= left_cnt_r)
    else $error("Character count exceeds the buffer capacity.");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !l_we && !r_we)
    else $error("Store written outside the execute cycle.");

endmodule

// ===== bench/cursor_line_edit_buffer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Cursor line-edit buffer testbench
// Drives edit commands through the start/busy handshake, predicts every result
// from a private copy of the two cursor stacks, and checks each result on its
// strobe. A directed part covers empty-buffer edits, out-of-range reads and
// unused command codes; random edit runs follow under three sender idle rates.
// ----------------------------------------------------------------------------
module cursor_line_edit_buffer_unit_tb;
  import cleb_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic [LEN_W-1:0]  text_length;
    logic [LEN_W-1:0]  cursor_at;
    logic [STAT_W-1:0] status;
  } edit_result_t;

  class edit_buffer_scoreboard;
    logic [CHAR_W-1:0] left_chars[CAPACITY];
    logic [CHAR_W-1:0] right_chars[CAPACITY];
    int unsigned       left_n;
    int unsigned       right_n;
    edit_result_t      expected_q[$];
    int unsigned       failures;

    function new();
      left_n   = 0;
      right_n  = 0;
      failures = 0;
    endfunction

    function int unsigned text_length();
      return left_n + right_n;
    endfunction

    function int unsigned cursor_pos();
      return left_n;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_command(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch,
                               logic [POS_W-1:0] pos);
      edit_result_t want;
      int unsigned  total;
      total         = left_n + right_n;
      want.char_out = '0;
      want.status   = STAT_DONE;
      case (kind)
        KIND_INSERT: begin
          if (total >= CAPACITY) begin
            want.status = STAT_FULL;
          end else begin
            left_chars[left_n] = ch;
            left_n++;
          end
        end
        KIND_LEFT: begin
          if (left_n == 0 || right_n >= CAPACITY) begin
            want.status = STAT_BOUNDARY;
          end else begin
            left_n--;
            right_chars[right_n] = left_chars[left_n];
            right_n++;
          end
        end
        KIND_RIGHT: begin
          if (right_n == 0 || left_n >= CAPACITY) begin
            want.status = STAT_BOUNDARY;
          end else begin
            right_n--;
            left_chars[left_n] = right_chars[right_n];
            left_n++;
          end
        end
        KIND_DELETE: begin
          if (left_n == 0) begin
            want.status = STAT_BOUNDARY;
          end else begin
            left_n--;
          end
        end
        KIND_READ: begin
          if (pos >= total) begin
            want.status = STAT_RANGE;
          end else if (pos < left_n) begin
            want.char_out = left_chars[pos];
          end else begin
            want.char_out = right_chars[right_n - 1 - (pos - left_n)];
          end
        end
        default: begin
          want.status = STAT_BOUNDARY;
        end
      endcase
      want.text_length = LEN_W'(left_n + right_n);
      want.cursor_at   = LEN_W'(left_n);
      expected_q.push_back(want);
    endfunction

    function void check_result(edit_result_t got);
      edit_result_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected result: char=%0h len=%0d cursor=%0d stat=%0d",
                   got.char_out, got.text_length, got.cursor_at, got.status);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.char_out !== want.char_out || got.text_length !== want.text_length ||
          got.cursor_at !== want.cursor_at || got.status !== want.status) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: expected char=%0h len=%0d cursor=%0d stat=%0d",
                   want.char_out, want.text_length, want.cursor_at, want.status);
          $display("          actual   char=%0h len=%0d cursor=%0d stat=%0d",
                   got.char_out, got.text_length, got.cursor_at, got.status);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [KIND_W-1:0] in_kind = '0;
  logic [CHAR_W-1:0] in_char_in = '0;
  logic [POS_W-1:0]  in_position = '0;
  logic              out_valid;
  logic [CHAR_W-1:0] out_char_out;
  logic [LEN_W-1:0]  out_text_length;
  logic [LEN_W-1:0]  out_cursor_at;
  logic [STAT_W-1:0] out_status;

  edit_buffer_scoreboard sb;
  int unsigned           idle_pct = 0;
  int unsigned           quiet_cycles = 0;

  cursor_line_edit_buffer_unit #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_char_in     (in_char_in),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_char_out   (out_char_out),
    .out_text_length(out_text_length),
    .out_cursor_at  (out_cursor_at),
    .out_status     (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result({out_char_out, out_text_length, out_cursor_at, out_status});
    end
    if (!rst_n || out_valid || (start && !busy)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic idle_cycle();
    @(negedge clk);
    start       <= 1'b0;
    in_kind     <= KIND_W'($urandom);
    in_char_in  <= CHAR_W'($urandom);
    in_position <= POS_W'($urandom);
  endtask

  task automatic issue_command(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch,
                               logic [POS_W-1:0] pos);
    while ($urandom_range(99) < idle_pct) idle_cycle();
    @(negedge clk);
    start       <= 1'b1;
    in_kind     <= kind;
    in_char_in  <= ch;
    in_position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(kind, ch, pos);
  endtask

  task automatic issue_edit(logic [KIND_W-1:0] kind);
    issue_command(kind, CHAR_W'($urandom), POS_W'($urandom));
  endtask

  task automatic issue_read(int unsigned pos);
    issue_command(KIND_READ, CHAR_W'($urandom), POS_W'(pos));
  endtask

  task automatic run_directed();
    issue_edit(KIND_LEFT);
    issue_edit(KIND_RIGHT);
    issue_edit(KIND_DELETE);
    issue_read(0);
    issue_read(1023);
    issue_edit(3'd5);
    issue_edit(3'd6);
    issue_edit(3'd7);
    issue_command(KIND_INSERT, 8'h00, '0);
    issue_command(KIND_INSERT, 8'hFF, '1);
    issue_command(KIND_INSERT, 8'hA5, '0);
    issue_read(0);
    issue_read(2);
    issue_read(3);
    issue_edit(KIND_LEFT);
    issue_edit(KIND_LEFT);
    issue_read(0);
    issue_read(1);
    issue_read(2);
    issue_edit(KIND_RIGHT);
    issue_edit(KIND_DELETE);
    issue_read(1);
    issue_edit(KIND_RIGHT);
    issue_edit(KIND_RIGHT);
  endtask

  task automatic run_random(int unsigned n_items);
    int unsigned sent;
    int unsigned choice;
    int unsigned run_len;
    sent = 0;
    while (sent < n_items) begin
      choice  = $urandom_range(99);
      run_len = $urandom_range(12, 1);
      repeat (run_len) begin
        if (choice < 32) begin
          issue_edit(sb.text_length() >= 300 ? KIND_DELETE : KIND_INSERT);
        end else if (choice < 46) begin
          issue_edit(KIND_LEFT);
        end else if (choice < 60) begin
          issue_edit(KIND_RIGHT);
        end else if (choice < 70) begin
          issue_edit(KIND_DELETE);
        end else if (choice < 85) begin
          issue_read($urandom_range(sb.text_length()));
        end else if (choice < 93) begin
          issue_read($urandom_range(1023));
        end else begin
          issue_edit(KIND_W'($urandom));
        end
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_pct = 6;
    run_directed();
    run_random(200);
    idle_pct = 82;
    run_random(200);
    idle_pct = 0;
    run_random(200);

    idle_cycle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/cleb_pkg.sv
sv/cleb_ram.sv
sv/cursor_line_edit_buffer_unit.sv
bench/cursor_line_edit_buffer_unit_tb.sv
